@@ hw/rtl/rmd_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// rmd_pkg
// Shared types and codes for the record marking deframer.
// ----------------------------------------------------------------------------
package rmd_pkg;

	// request codes
	localparam logic [1:0] REQ_BYTE = 2'd0;
	localparam logic [1:0] REQ_END  = 2'd1;
	localparam logic [1:0] REQ_SKIP = 2'd2;

	// status codes
	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_REFUSED   = 2'd1;
	localparam logic [1:0] ST_PREMATURE = 2'd2;

	localparam int LEN_W     = 31;
	localparam int HDR_LAST  = 3;

	typedef struct packed {
		logic [1:0] req_type;
		logic [7:0] in_byte;
	} item_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       byte_valid;
		logic       fragment_end;
		logic       record_end;
		logic [1:0] status;
	} result_t;

endpackage
`default_nettype wire

@@ hw/rtl/rmd_if.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// rmd_req_if / rmd_res_if
// Valid/ready channels for requests and results.
// ----------------------------------------------------------------------------
interface rmd_req_if import rmd_pkg::*; ();
	logic       valid;
	logic       ready;
	logic [1:0] req_type;
	logic [7:0] in_byte;

	modport source (output valid, output req_type, output in_byte, input ready);
	modport sink (input valid, input req_type, input in_byte, output ready);
endinterface

interface rmd_res_if import rmd_pkg::*; ();
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       byte_valid;
	logic       fragment_end;
	logic       record_end;
	logic [1:0] status;

	modport source (output valid, output out_byte, output byte_valid,
		output fragment_end, output record_end, output status, input ready);
	modport sink (input valid, input out_byte, input byte_valid,
		input fragment_end, input record_end, input status, output ready);
endinterface
`default_nettype wire

@@ hw/rtl/rmd_in_stage.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// rmd_in_stage
// Input register for one request.
// ----------------------------------------------------------------------------
module rmd_in_stage import rmd_pkg::*; (
	input  wire logic  clk,
	input  wire logic  arst_n,
	rmd_req_if.sink    rx,
	input  wire logic  adv,
	output logic       valid_s1,
	output item_t      item_s1
);

	assign rx.ready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (rx.ready) begin
			valid_s1 <= rx.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rx.ready && rx.valid) begin
			item_s1.req_type <= rx.req_type;
			item_s1.in_byte  <= rx.in_byte;
		end
	end

endmodule
`default_nettype wire

@@ hw/rtl/rmd_core.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// rmd_core
// Deframer state and next-state logic; state moves when a request advances.
// ----------------------------------------------------------------------------
module rmd_core import rmd_pkg::*; (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  adv,
	input  wire item_t item,
	output result_t    res
);

	logic [1:0]       hdr_cnt_q,  hdr_cnt_n;
	logic [23:0]      hdr_sh_q,   hdr_sh_n;
	logic [LEN_W-1:0] left_q,     left_n;
	logic             last_q,     last_n;
	logic             done_q,     done_n;
	logic             skip_q,     skip_n;

	logic             fin;
	logic             fin_last;
	logic [31:0]      word;

	assign word = {hdr_sh_q, item.in_byte};

	always_comb begin
		hdr_cnt_n = hdr_cnt_q;
		hdr_sh_n  = hdr_sh_q;
		left_n    = left_q;
		last_n    = last_q;
		done_n    = done_q;
		skip_n    = skip_q;
		fin       = 1'b0;
		fin_last  = 1'b0;
		res       = '0;

		unique case (item.req_type)
			REQ_BYTE: begin
				if (done_q) begin
					res.status = ST_REFUSED;
				end else if (left_q == '0) begin
					if (hdr_cnt_q != 2'(HDR_LAST)) begin
						hdr_sh_n  = {hdr_sh_q[15:0], item.in_byte};
						hdr_cnt_n = hdr_cnt_q + 2'd1;
					end else begin
						hdr_cnt_n = '0;
						hdr_sh_n  = '0;
						left_n    = word[LEN_W-1:0];
						last_n    = word[31];
						fin       = (word[LEN_W-1:0] == '0);
						fin_last  = word[31];
					end
				end else begin
					left_n = left_q - LEN_W'(1);
					if (!skip_q) begin
						res.out_byte   = item.in_byte;
						res.byte_valid = 1'b1;
					end
					fin      = (left_q == LEN_W'(1));
					fin_last = last_q;
				end
			end
			REQ_END: begin
				if (done_q) begin
					done_n = 1'b0;
					last_n = 1'b0;
				end else begin
					res.status = ST_PREMATURE;
					hdr_cnt_n  = '0;
					hdr_sh_n   = '0;
					left_n     = '0;
					last_n     = 1'b0;
					skip_n     = 1'b0;
				end
			end
			REQ_SKIP: begin
				if (!done_q) begin
					skip_n = 1'b1;
				end
			end
			default: begin
			end
		endcase

		// end of fragment; a last fragment closes the record or ends a skip
		if (fin) begin
			res.fragment_end = 1'b1;
			if (fin_last) begin
				res.record_end = 1'b1;
				if (skip_q) begin
					skip_n = 1'b0;
					last_n = 1'b0;
				end else begin
					done_n = 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hdr_cnt_q <= '0;
			hdr_sh_q  <= '0;
			left_q    <= '0;
			last_q    <= 1'b0;
			done_q    <= 1'b0;
			skip_q    <= 1'b0;
		end else if (adv) begin
			hdr_cnt_q <= hdr_cnt_n;
			hdr_sh_q  <= hdr_sh_n;
			left_q    <= left_n;
			last_q    <= last_n;
			done_q    <= done_n;
			skip_q    <= skip_n;
		end
	end

endmodule
`default_nettype wire

@@ hw/rtl/rmd_out_stage.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// rmd_out_stage
// Result register driving the result channel.
// ----------------------------------------------------------------------------
module rmd_out_stage import rmd_pkg::*; (
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    load,
	input  wire result_t res,
	output logic         can_load,
	rmd_res_if.source    tx
);

	logic    valid_s2;
	result_t res_s2;

	assign can_load = !valid_s2 || tx.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (can_load) begin
			valid_s2 <= load;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			res_s2 <= res;
		end
	end

	assign tx.valid        = valid_s2;
	assign tx.out_byte     = res_s2.out_byte;
	assign tx.byte_valid   = res_s2.byte_valid;
	assign tx.fragment_end = res_s2.fragment_end;
	assign tx.record_end   = res_s2.record_end;
	assign tx.status       = res_s2.status;

endmodule
`default_nettype wire

@@ hw/rtl/rpc_record_marking_deframer_top.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// rpc_record_marking_deframer_top
// RPC record marking deframer: strips 4-byte fragment headers from a byte
// stream and marks fragment and record ends on the payload.
// ----------------------------------------------------------------------------
// Throughput is one request per cycle, sustained while the result side
// does not stall; every request returns exactly one result, held first in
// the input register and then in the result register. The figure is set by
// the single next-state pass in rmd_core: header gathering, the 31-bit
// length countdown and the record flags all update between the two registers.
// Request codes: 0 stream byte, 1 end_record acknowledge, 2 skip the rest of
// the record; code 3 is ignored and returns an all-zero result. After a record
// ends, stream bytes are refused (status 1) until an end_record arrives; an
// end_record with no record ended reports status 2 and resyncs to a header.
// The result register lets one more request be taken while a result waits.
// ----------------------------------------------------------------------------
module rpc_record_marking_deframer_top import rmd_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	rmd_req_if.sink   rx,
	rmd_res_if.source tx
);

	logic    valid_s1;
	item_t   item_s1;
	logic    can_load;
	logic    adv;
	result_t res;

	// request leaves the input register when the result register has room
	assign adv = valid_s1 && can_load;

	rmd_in_stage u_in (
		.clk      (clk),
		.arst_n   (arst_n),
		.rx       (rx),
		.adv      (adv),
		.valid_s1 (valid_s1),
		.item_s1  (item_s1)
	);

	// deframer state commits only on adv
	rmd_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.adv    (adv),
		.item   (item_s1),
		.res    (res)
	);

	rmd_out_stage u_out (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (adv),
		.res      (res),
		.can_load (can_load),
		.tx       (tx)
	);

endmodule
`default_nettype wire

@@ tb/sv/rmd_checker.sv @@
// ----------------------------------------------------------------------------
// rmd_checker
// Watches the request and result channels of the record marking deframer,
// keeps its own model of the framing state, and checks every result in order.
// ----------------------------------------------------------------------------
module rmd_checker import rmd_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	rmd_req_if   rx,
	rmd_res_if   tx,
	output int   errors,
	output int   pending,
	output int   n_requests,
	output int   n_records,
	output int   n_refused,
	output int   n_resyncs
);
	timeunit 1ns;
	timeprecision 1ps;

	// framing state
	logic [2:0]       hdr_cnt   = '0;
	logic [23:0]      hdr_acc   = '0;
	logic [LEN_W-1:0] remaining = '0;
	logic             last_frag = 1'b0;
	logic             rec_done  = 1'b0;
	logic             dropping  = 1'b0;

	result_t due_results[$];
	int      err_cnt  = 0;
	int      res_cnt  = 0;
	int      req_cnt  = 0;
	int      rec_cnt  = 0;
	int      ref_cnt  = 0;
	int      sync_cnt = 0;

	// fragment complete; a last fragment closes the record, or re-arms if skipping
	function automatic void close_fragment(inout result_t r);
		r.fragment_end = 1'b1;
		if (last_frag) begin
			r.record_end = 1'b1;
			if (dropping) begin
				dropping  = 1'b0;
				last_frag = 1'b0;
			end else begin
				rec_done = 1'b1;
			end
		end
	endfunction

	function automatic result_t deframe(input item_t it);
		result_t     r;
		logic [31:0] word;
		r = '0;
		case (it.req_type)
			REQ_BYTE: begin
				if (rec_done) begin
					r.status = ST_REFUSED;
				end else if (remaining == '0) begin
					if (hdr_cnt < HDR_LAST) begin
						hdr_acc = {hdr_acc[15:0], it.in_byte};
						hdr_cnt = hdr_cnt + 3'd1;
					end else begin
						word      = {hdr_acc, it.in_byte};
						hdr_cnt   = '0;
						hdr_acc   = '0;
						remaining = word[LEN_W-1:0];
						last_frag = word[31];
						if (remaining == '0)
							close_fragment(r);
					end
				end else begin
					remaining = remaining - 1'b1;
					if (!dropping) begin
						r.out_byte   = it.in_byte;
						r.byte_valid = 1'b1;
					end
					if (remaining == '0)
						close_fragment(r);
				end
			end
			REQ_END: begin
				if (rec_done) begin
					rec_done  = 1'b0;
					last_frag = 1'b0;
				end else begin
					// ack with no record ended: drop everything, expect a header
					r.status  = ST_PREMATURE;
					hdr_cnt   = '0;
					hdr_acc   = '0;
					remaining = '0;
					last_frag = 1'b0;
					rec_done  = 1'b0;
					dropping  = 1'b0;
				end
			end
			REQ_SKIP: begin
				if (!rec_done)
					dropping = 1'b1;
			end
			default: ;
		endcase
		return r;
	endfunction

	always @(posedge clk) begin
		result_t got;
		result_t want;
		item_t   it;
		if (arst_n) begin
			if (tx.valid && tx.ready) begin
				got.out_byte     = tx.out_byte;
				got.byte_valid   = tx.byte_valid;
				got.fragment_end = tx.fragment_end;
				got.record_end   = tx.record_end;
				got.status       = tx.status;
				res_cnt++;
				if (got.record_end === 1'b1)
					rec_cnt++;
				if (due_results.size() == 0) begin
					err_cnt++;
					if (err_cnt <= 10)
						$display("result %0d arrived with nothing pending", res_cnt);
				end else begin
					want = due_results.pop_front();
					if (got.out_byte !== want.out_byte || got.byte_valid !== want.byte_valid ||
						got.fragment_end !== want.fragment_end ||
						got.record_end !== want.record_end || got.status !== want.status) begin
						err_cnt++;
						if (err_cnt <= 10)
							$display("result %0d: expected byte %h/%b frag %b rec %b st %0d, got byte %h/%b frag %b rec %b st %0d",
								res_cnt, want.out_byte, want.byte_valid, want.fragment_end,
								want.record_end, want.status, got.out_byte, got.byte_valid,
								got.fragment_end, got.record_end, got.status);
					end
				end
			end
			if (rx.valid && rx.ready) begin
				it.req_type = rx.req_type;
				it.in_byte  = rx.in_byte;
				req_cnt++;
				want = deframe(it);
				if (want.status == ST_REFUSED)
					ref_cnt++;
				if (want.status == ST_PREMATURE)
					sync_cnt++;
				due_results.push_back(want);
			end
		end
		errors     <= err_cnt;
		pending    <= due_results.size();
		n_requests <= req_cnt;
		n_records  <= rec_cnt;
		n_refused  <= ref_cnt;
		n_resyncs  <= sync_cnt;
	end

endmodule

@@ tb/sv/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the record marking deframer. A short directed run
// hits the corner cases, then mostly well-formed records with random headers,
// payload and skips are mixed with broken fragments and noise requests. Both
// channel sides stall at random; rmd_checker does all result checking.
// ----------------------------------------------------------------------------
module tb_top import rmd_pkg::*; ();
	timeunit 1ns;
	timeprecision 1ps;

	// request code the block ignores (all-zero result)
	localparam logic [1:0] REQ_UNUSED = 2'd3;
	// cycle limit for the whole run
	localparam int CYCLE_LIMIT = 400000;
	localparam int RANDOM_ITEMS = 1000;
	localparam int PHASE_ITEMS = 150;

	// pacing of both sides: full random stalls, none, or occasional ones
	typedef enum int {PACE_FULL, PACE_NONE, PACE_LIGHT} pace_e;

	logic  clk = 1'b0;
	logic  arst_n;
	pace_e pace = PACE_FULL;
	int    sent = 0;      // requests accepted, ignored codes not counted
	int    cycles = 0;

	int errors, pending, n_requests, n_records, n_refused, n_resyncs;

	rmd_req_if rx_ch ();
	rmd_res_if tx_ch ();

	rpc_record_marking_deframer_top dut (
		.clk    (clk),
		.arst_n (arst_n),
		.rx     (rx_ch),
		.tx     (tx_ch)
	);

	rmd_checker chk (
		.clk        (clk),
		.arst_n     (arst_n),
		.rx         (rx_ch),
		.tx         (tx_ch),
		.errors     (errors),
		.pending    (pending),
		.n_requests (n_requests),
		.n_records  (n_records),
		.n_refused  (n_refused),
		.n_resyncs  (n_resyncs)
	);

	always #6 clk = ~clk;

	// hard stop in case a handshake hangs
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding", cycles, pending);
			$display("tb_top failed");
			$finish;
		end
	end

	// idle cycles before the next request or result, drawn per item
	function automatic int idle_draw();
		case (pace)
			PACE_NONE:  return 0;
			PACE_LIGHT: return ($urandom_range(0, 3) == 0) ? $urandom_range(1, 14) : 0;
			default:    return $urandom_range(0, 14);
		endcase
	endfunction

	// Result side: one result per loop pass. ready is only changed at an edge,
	// and stays high across back-to-back results when no stall is drawn.
	initial begin
		int stall;
		tx_ch.ready <= 1'b0;
		@(posedge clk iff arst_n);
		forever begin
			stall = idle_draw();
			if (stall > 0) begin
				tx_ch.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			tx_ch.ready <= 1'b1;
			@(posedge clk);
			while (!tx_ch.valid)
				@(posedge clk);
		end
	end

	// One request: optional gap, then hold valid until ready is seen at an edge.
	// A zero gap keeps valid high, so back-to-back requests get one NBA per step.
	task automatic put(input logic [1:0] req, input logic [7:0] b);
		int gap;
		gap = idle_draw();
		if (gap > 0) begin
			rx_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		rx_ch.valid    <= 1'b1;
		rx_ch.req_type <= req;
		rx_ch.in_byte  <= b;
		@(posedge clk);
		while (!rx_ch.ready)
			@(posedge clk);
		if (req != REQ_UNUSED)
			sent++;
	endtask

	// Stop sending and wait until every request has its result back.
	// The first edge lets the checker see the last accepted request.
	task automatic drain();
		rx_ch.valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
	endtask

	// Header then random payload. skip_at puts a skip in front of stream byte
	// skip_at (header bytes counted), so the skip always lands before the
	// fragment's final byte; -1 for no skip.
	task automatic send_fragment(input bit last, input logic [LEN_W-1:0] len, input int skip_at);
		logic [31:0] word;
		word = {last, len};
		for (int i = 0; i < 4 + int'(len); i++) begin
			if (i == skip_at)
				put(REQ_SKIP, 8'($urandom));
			if (i < 4)
				put(REQ_BYTE, word[8*(3-i) +: 8]);
			else
				put(REQ_BYTE, 8'($urandom));
		end
	endtask

	// Well-formed record of 1..3 fragments, mostly short. A skip in any
	// fragment lets the block re-arm on its own, otherwise an end_record
	// follows, sometimes after a few refused bytes and an ignored skip.
	task automatic send_record();
		int nfrag;
		int skip_frag;
		int len;
		bit skipped;
		nfrag     = $urandom_range(1, 3);
		skip_frag = ($urandom_range(0, 4) == 0) ? $urandom_range(0, nfrag - 1) : -1;
		skipped   = 1'b0;
		for (int f = 0; f < nfrag; f++) begin
			len = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 40) : $urandom_range(0, 6);
			if (f == skip_frag) begin
				skipped = 1'b1;
				send_fragment(f == nfrag - 1, LEN_W'(len), $urandom_range(0, 3 + len));
			end else begin
				send_fragment(f == nfrag - 1, LEN_W'(len), -1);
			end
		end
		if (!skipped) begin
			if ($urandom_range(0, 3) == 0) begin
				repeat ($urandom_range(1, 2))
					put(REQ_BYTE, 8'($urandom));
				put(REQ_SKIP, 8'($urandom));
			end
			put(REQ_END, 8'($urandom));
		end else if ($urandom_range(0, 4) == 0) begin
			// block already re-armed, so this ack comes too early
			put(REQ_END, 8'($urandom));
		end
	endtask

	// Random header word, cut off after a few bytes, then resync by end_record.
	task automatic send_broken();
		logic [31:0] word;
		int          cut;
		word = $urandom;
		cut  = $urandom_range(1, 6);
		for (int i = 0; i < cut; i++)
			put(REQ_BYTE, (i < 4) ? word[8*(3-i) +: 8] : 8'($urandom));
		put(REQ_END, 8'($urandom));
	endtask

	// Any request codes, ignored one included; end_record always resyncs after.
	task automatic send_noise();
		repeat ($urandom_range(1, 4))
			put(2'($urandom_range(0, 3)), 8'($urandom));
		put(REQ_END, 8'($urandom));
	endtask

	initial begin
		int pick;
		int phase_mark;
		arst_n         <= 1'b0;
		rx_ch.valid    <= 1'b0;
		rx_ch.req_type <= REQ_BYTE;
		rx_ch.in_byte  <= 8'h00;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		// ---- directed corner cases ----
		put(REQ_END, 8'h00);              // end_record with no record ended
		put(REQ_UNUSED, 8'hFF);           // undefined code, zero result
		send_fragment(1'b1, '0, -1);      // empty last fragment closes the record
		put(REQ_BYTE, 8'hFF);             // refused after record end
		put(REQ_SKIP, 8'h00);             // skip while waiting for ack: no effect
		put(REQ_END, 8'hFF);              // timely ack re-arms
		put(REQ_BYTE, 8'h00);             // non-last fragment, two payload bytes
		put(REQ_BYTE, 8'h00);
		put(REQ_BYTE, 8'h00);
		put(REQ_BYTE, 8'h02);
		put(REQ_BYTE, 8'h00);
		put(REQ_BYTE, 8'hFF);
		send_fragment(1'b1, LEN_W'(1), 4); // skip over the only payload byte, self re-arm
		repeat (4)
			put(REQ_BYTE, 8'hFF);          // last flag with maximum length
		put(REQ_BYTE, 8'h5A);
		put(REQ_END, 8'h00);              // cut the long fragment short
		drain();

		// ---- random part, pacing changes every phase ----
		phase_mark = sent;
		while (sent < RANDOM_ITEMS + 27) begin
			if (sent - phase_mark >= PHASE_ITEMS) begin
				drain();
				pace       = pace_e'($urandom_range(0, 2));
				phase_mark = sent;
			end
			pick = $urandom_range(0, 99);
			if (pick < 75)
				send_record();
			else if (pick < 88)
				send_broken();
			else
				send_noise();
		end
		drain();
		repeat (10) @(posedge clk);

		$display("covered %0d requests: %0d records closed, %0d refused bytes, %0d early acks",
			n_requests, n_records, n_refused, n_resyncs);
		$display("%0d mismatching results, %0d cycles", errors, cycles);
		if (errors == 0)
			$display("tb_top passed");
		else
			$display("tb_top failed");
		$finish;
	end

endmodule
